// ===== hdl/i2cmbe_pkg.sv =====
// Package: command codes, widths and shared types of the I2C master bit engine.
package i2cmbe_pkg;

  localparam int unsigned OpcodeW     = 3;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned PhaseW      = 5;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [ByteW-1:0] AckLimitReset = 8'd250;

  typedef enum logic [OpcodeW-1:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_WAIT_ACK  = 3'd4,
    CMD_READ_ACK  = 3'd5,
    CMD_READ_NACK = 3'd6
  } cmd_e;

  // Classified tick as it travels from the front end to the sequencer.
  typedef struct packed {
    cmd_e             cmd;
    logic [ByteW-1:0] write_byte;
    logic             sda_in;
  } tick_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_enable;
    logic             sda_level;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_byte;
    logic             ack_failed;
  } result_t;

  // Queue handshake toward the sequencer.
  typedef struct packed {
    logic valid;
    logic ready;
  } queue_hs_t;

endpackage

// ===== hdl/i2cmbe_if.sv =====
// Interfaces: tick input, result output and configuration write channels.
interface i2cmbe_in_if;
  import i2cmbe_pkg::*;
  logic               valid;
  logic               ready;
  logic [OpcodeW-1:0] opcode;
  logic [ByteW-1:0]   write_byte;
  logic               sda_in;
  modport source (output valid, opcode, write_byte, sda_in, input ready);
  modport sink   (input valid, opcode, write_byte, sda_in, output ready);
endinterface

interface i2cmbe_out_if;
  import i2cmbe_pkg::*;
  logic             valid;
  logic             ready;
  logic             scl_level;
  logic             sda_enable;
  logic             sda_level;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] read_byte;
  logic             ack_failed;
  modport source (output valid, scl_level, sda_enable, sda_level, busy_res, done_res,
                  read_byte, ack_failed, input ready);
  modport sink   (input valid, scl_level, sda_enable, sda_level, busy_res, done_res,
                  read_byte, ack_failed, output ready);
endinterface

interface i2cmbe_cfg_if;
  import i2cmbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] ack_timeout_limit;
  modport source (output valid, ack_timeout_limit, input ready);
  modport sink   (input valid, ack_timeout_limit, output ready);
endinterface

// ===== hdl/i2c_master_bit_engine.sv =====
// I2C master bit engine: each accepted tick word yields exactly one result word
// with the SCL level, SDA drive and enable, busy, done, last read byte and the
// acknowledge-failure flag. A front end classifies the opcode and stores the tick
// in a two-entry queue; the sequencer takes one tick per clock while the result
// register is free or being taken, and registers its result, so the engine
// sustains one tick per clock cycle when the result output is not stalled. A
// result word is valid from the clock edge at which its tick leaves the queue.
// Commands arriving while a sequence runs are ignored. The timeout limit is
// written through the configuration channel, which is always ready.
module i2c_master_bit_engine #(
  parameter int unsigned QUEUE_DEPTH = i2cmbe_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cmbe_in_if.sink     in_i,
  i2cmbe_cfg_if.sink    cfg_i,
  i2cmbe_out_if.source  out_o
);
  import i2cmbe_pkg::*;

  logic      push;
  tick_t     push_data;
  logic      queue_full;
  queue_hs_t queue_hs;
  logic      pop;
  tick_t     head;

  i2cmbe_front u_front (
    .in_i         (in_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  i2cmbe_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_hs_o    (queue_hs),
    .pop_i       (pop),
    .pop_data_o  (head)
  );

  i2cmbe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .queue_hs_i (queue_hs),
    .tick_i     (head),
    .pop_o      (pop),
    .cfg_i      (cfg_i),
    .out_o      (out_o)
  );

endmodule

// ===== hdl/i2cmbe_queue.sv =====
// Small flop-based FIFO of classified ticks between front end and sequencer.
module i2cmbe_queue #(
  parameter int unsigned Depth = i2cmbe_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  i2cmbe_pkg::tick_t   push_data_i,
  output logic                full_o,
  output i2cmbe_pkg::queue_hs_t pop_hs_o,
  input  logic                pop_i,
  output i2cmbe_pkg::tick_t   pop_data_o
);
  import i2cmbe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tick_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(Depth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

  assign full_o         = (count_q == CntW'(Depth));
  assign pop_hs_o.valid = (count_q != '0);
  assign pop_hs_o.ready = pop_i;
  assign pop_data_o     = mem_q[rd_ptr_q];
  assign do_push        = push_i & ~full_o;
  assign do_pop         = pop_i & pop_hs_o.valid;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/i2cmbe_front.sv =====
// Front end: accept tick words, classify the opcode and push them into the queue.
module i2cmbe_front (
  i2cmbe_in_if.sink         in_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output i2cmbe_pkg::tick_t push_data_o
);
  import i2cmbe_pkg::*;

  cmd_e cmd;

  // Drop unused opcode seven to no command.
  always_comb begin
    unique case (in_i.opcode)
      CMD_START:     cmd = CMD_START;
      CMD_STOP:      cmd = CMD_STOP;
      CMD_WRITE:     cmd = CMD_WRITE;
      CMD_WAIT_ACK:  cmd = CMD_WAIT_ACK;
      CMD_READ_ACK:  cmd = CMD_READ_ACK;
      CMD_READ_NACK: cmd = CMD_READ_NACK;
      default:       cmd = CMD_NONE;
    endcase
  end

  assign in_i.ready             = ~queue_full_i;
  assign push_o                 = in_i.valid & ~queue_full_i;
  assign push_data_o.cmd        = cmd;
  assign push_data_o.write_byte = in_i.write_byte;
  assign push_data_o.sda_in     = in_i.sda_in;

endmodule

// ===== hdl/i2cmbe_back.sv =====
// Back end: line sequencer, at most one phase per tick, with registered result.
module i2cmbe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cmbe_pkg::queue_hs_t queue_hs_i,
  input  i2cmbe_pkg::tick_t     tick_i,
  output logic                  pop_o,
  i2cmbe_cfg_if.sink            cfg_i,
  i2cmbe_out_if.source          out_o
);
  import i2cmbe_pkg::*;

  localparam logic [PhaseW-1:0] RwBitPhases = PhaseW'(2 * BitsPerByte);
  localparam logic [PhaseW-1:0] LastBitPh   = PhaseW'(2 * BitsPerByte - 1);

  cmd_e              active_q, active_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  shift_q, shift_d;
  logic [ByteW-1:0]  tmo_q, tmo_d;
  logic [ByteW-1:0]  held_q, held_d;
  logic [ByteW-1:0]  limit_q;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              sda_en_q, sda_en_d;
  logic              fail_q, fail_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;
  logic              done;
  logic [PhaseW-1:0] p;
  logic [PhaseW-1:0] next;

  assign cfg_i.ready = 1'b1;
  // Advance when the result register is free or being taken this cycle.
  assign pop_o       = queue_hs_i.valid & (~out_valid_q | out_o.ready);

  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    shift_d  = shift_q;
    tmo_d    = tmo_q;
    held_d   = held_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    sda_en_d = sda_en_q;
    fail_d   = fail_q;
    done     = 1'b0;
    p        = '0;
    next     = '0;
    if (pop_o) begin
      if (active_q == CMD_NONE && tick_i.cmd != CMD_NONE) begin
        active_d = tick_i.cmd;
        phase_d  = '0;
        priority case (tick_i.cmd)
          CMD_WRITE: shift_d = tick_i.write_byte;
          CMD_WAIT_ACK: begin
            tmo_d  = '0;
            fail_d = 1'b0;
          end
          CMD_READ_ACK, CMD_READ_NACK: shift_d = '0;
          default: ;
        endcase
      end
      if (active_d != CMD_NONE) begin
        p    = phase_d;
        next = p + PhaseW'(1);
        unique case (active_d)
          CMD_START: begin
            sda_en_d = 1'b1;
            if (p == PhaseW'(0)) begin
              scl_d = 1'b1; sda_d = 1'b1;
            end else if (p == PhaseW'(1)) begin
              scl_d = 1'b1; sda_d = 1'b0;
            end else begin
              scl_d = 1'b0; sda_d = 1'b0; done = 1'b1;
            end
          end
          CMD_STOP: begin
            sda_en_d = 1'b1;
            if (p == PhaseW'(0)) begin
              scl_d = 1'b0; sda_d = 1'b0;
            end else begin
              scl_d = 1'b1; sda_d = 1'b1; done = 1'b1;
            end
          end
          CMD_WRITE: begin
            sda_en_d = 1'b1;
            sda_d    = shift_d[ByteW-1];
            if (!p[0]) begin
              scl_d = 1'b1;
            end else begin
              scl_d   = 1'b0;
              shift_d = {shift_d[ByteW-2:0], 1'b0};
              if (p >= LastBitPh) begin
                done = 1'b1;
              end
            end
          end
          CMD_WAIT_ACK: begin
            if (p == PhaseW'(0)) begin
              sda_en_d = 1'b0; sda_d = 1'b1;
            end else if (p == PhaseW'(1)) begin
              scl_d = 1'b1;
            end else if (p == PhaseW'(2)) begin
              scl_d = 1'b1;
              if (!tick_i.sda_in) begin
                scl_d = 1'b0; done = 1'b1;
              end else if (tmo_d >= limit_q) begin
                // Timed out: pull SDA low, then finish with the stop edge.
                fail_d   = 1'b1;
                scl_d    = 1'b0; sda_d = 1'b0; sda_en_d = 1'b1;
                next     = PhaseW'(3);
              end else begin
                tmo_d = tmo_d + ByteW'(1);
                next  = PhaseW'(2);
              end
            end else begin
              sda_en_d = 1'b1;
              scl_d = 1'b1; sda_d = 1'b1; done = 1'b1;
            end
          end
          CMD_READ_ACK, CMD_READ_NACK: begin
            if (p < RwBitPhases) begin
              sda_en_d = 1'b0; sda_d = 1'b1;
              if (!p[0]) begin
                scl_d = 1'b0;
              end else begin
                scl_d   = 1'b1;
                shift_d = {shift_d[ByteW-2:0], tick_i.sda_in};
                if (p == LastBitPh) begin
                  held_d = shift_d;
                end
              end
            end else if (p == RwBitPhases) begin
              scl_d    = 1'b0; sda_en_d = 1'b1;
              sda_d    = (active_d == CMD_READ_NACK);
            end else if (p == RwBitPhases + PhaseW'(1)) begin
              scl_d = 1'b1;
            end else begin
              scl_d = 1'b0; done = 1'b1;
            end
          end
          default: ;
        endcase
        if (done) begin
          active_d = CMD_NONE;
          phase_d  = '0;
        end else begin
          phase_d = next;
        end
      end
    end
  end

  always_comb begin
    res_d.scl_level  = scl_d;
    res_d.sda_enable = sda_en_d;
    res_d.sda_level  = sda_d;
    res_d.busy_res   = (active_d != CMD_NONE);
    res_d.done_res   = done;
    res_d.read_byte  = held_d;
    res_d.ack_failed = fail_d;
    out_valid_d      = pop_o | (out_valid_q & ~out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= CMD_NONE;
      phase_q     <= '0;
      shift_q     <= '0;
      tmo_q       <= '0;
      held_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      sda_en_q    <= 1'b1;
      fail_q      <= 1'b0;
      limit_q     <= AckLimitReset;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      tmo_q       <= tmo_d;
      held_q      <= held_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      sda_en_q    <= sda_en_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        limit_q <= cfg_i.ack_timeout_limit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.scl_level  = res_q.scl_level;
  assign out_o.sda_enable = res_q.sda_enable;
  assign out_o.sda_level  = res_q.sda_level;
  assign out_o.busy_res   = res_q.busy_res;
  assign out_o.done_res   = res_q.done_res;
  assign out_o.read_byte  = res_q.read_byte;
  assign out_o.ack_failed = res_q.ack_failed;

endmodule
